### rtl/core/sbs_pkg.sv
// shared constants, register codes and control structs for the spectrum bar smoother
package sbs_pkg;

  // sizing
  localparam int BUCKETS   = 64;
  localparam int BAR_WIDTH = 2;

  // field widths
  localparam int IDX_W    = 6;
  localparam int EN_W     = 16;
  localparam int COL_OUT_W = 8;
  localparam int HGT_W    = 7;
  localparam int CLR_W    = 24;
  localparam int DW_W     = 8;
  localparam int CFG_AW   = 2;

  // derived widths
  localparam int BKT_AW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BX_W    = $clog2(BAR_WIDTH) + 1;
  localparam int COL_W   = IDX_W + $clog2(BAR_WIDTH) + 2;
  localparam int IN_TD_W  = 24;
  localparam int OUT_TD_W = 40;

  // fixed-point constants
  localparam logic [31:0] W_NEW  = 32'd19661;
  localparam logic [31:0] W_OLD  = 32'd45875;
  localparam logic [31:0] Q_HALF = 32'd32768;
  localparam logic [20:0] Q_ONE  = 21'd65536;
  localparam logic [20:0] SCALE  = 21'd20;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_BAR_COLOR      = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DISPLAY_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DISPLAY_HEIGHT = 2'd2;

  // reset values
  localparam logic [CLR_W-1:0] BAR_COLOR_RST = 24'hFFFFFF;
  localparam logic [DW_W-1:0]  DISP_W_RST    = 8'd32;
  localparam logic [HGT_W-1:0] DISP_H_RST    = 7'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // latch input, read bucket store
    logic mul_old;    // add weighted old value
    logic update;     // write new smoothed value, saturate fraction
    logic height;     // compute bar height
    logic emit_load;  // load one column into the output register
  } sbs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_ok;      // bucket index in range
    logic col_ok;     // current column inside display
    logic col_last;   // current column is the final one of this bucket
    logic out_free;   // output register can take a result
  } sbs_sts_t;

endpackage

### rtl/core/sbs_ctrl.sv
// sequencing state machine for the spectrum bar smoother
module sbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sbs_pkg::sbs_sts_t sts,
  output sbs_pkg::sbs_cmd_t cmd
);
  import sbs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_HGT  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && sts.in_ok) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_old = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_HGT;
      end
      S_HGT: begin
        cmd.height = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.col_ok) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.col_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/sbs_datapath.sv
// bucket store, smoothing arithmetic, config registers and output register
module sbs_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sbs_pkg::IN_TD_W-1:0]     in_tdata,
  input  logic                            cfg_we,
  input  logic [sbs_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [sbs_pkg::CLR_W-1:0]       cfg_wdata,
  input  sbs_pkg::sbs_cmd_t               cmd,
  output sbs_pkg::sbs_sts_t               sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sbs_pkg::OUT_TD_W-1:0]    out_tdata,
  output logic                            out_tlast
);
  import sbs_pkg::*;

  // config registers
  logic [CLR_W-1:0] bar_color_r;
  logic [DW_W-1:0]  disp_w_r;
  logic [HGT_W-1:0] disp_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_color_r <= BAR_COLOR_RST;
      disp_w_r    <= DISP_W_RST;
      disp_h_r    <= DISP_H_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BAR_COLOR:      bar_color_r <= cfg_wdata;
        REG_DISPLAY_WIDTH:  disp_w_r    <= cfg_wdata[DW_W-1:0];
        REG_DISPLAY_HEIGHT: disp_h_r    <= cfg_wdata[HGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input fields
  logic [IDX_W-1:0]        in_idx;
  logic [EN_W-1:0]         in_energy;
  logic [BKT_AW+IDX_W-1:0] in_idx_ext;
  logic [BKT_AW-1:0]       rd_addr;

  assign in_idx     = in_tdata[IDX_W-1:0];
  assign in_energy  = in_tdata[IDX_W+EN_W-1:IDX_W];
  assign in_idx_ext = {{BKT_AW{1'b0}}, in_idx};
  assign rd_addr    = in_idx_ext[BKT_AW-1:0];
  assign sts.in_ok  = (9'(in_idx) < 9'(BUCKETS));

  // item registers
  logic [IDX_W-1:0]   idx_r;
  logic [31:0]        acc_r;
  logic [16:0]        frac_r;
  logic [HGT_W-1:0]   h_r;
  logic [BX_W-1:0]    bx_r;
  logic [EN_W-1:0]    rd_r;
  logic               rdv_r;

  logic [BKT_AW+IDX_W-1:0] idx_ext;
  logic [BKT_AW-1:0]       wr_addr;
  logic [EN_W-1:0]         old_val;
  logic [EN_W-1:0]         s_new;
  logic [20:0]             scaled;
  logic [23:0]             hprod;

  assign idx_ext = {{BKT_AW{1'b0}}, idx_r};
  assign wr_addr = idx_ext[BKT_AW-1:0];
  assign old_val = rdv_r ? rd_r : '0;
  assign s_new   = acc_r[31:16];
  assign scaled  = 21'(s_new) * SCALE;
  assign hprod   = 24'(frac_r) * 24'(disp_h_r) + Q_HALF[23:0];

  // bucket store, entries without a valid bit read as zero
  logic [EN_W-1:0]    mem [BUCKETS];
  logic [BUCKETS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[wr_addr] <= s_new;
    end
    if (cmd.accept) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.accept) begin
        rdv_r <= vld_r[rd_addr];
      end
    end
  end

  // ema, saturation and height, one multiply per step
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_idx;
      acc_r <= 32'(in_energy) * W_NEW + Q_HALF;
    end
    if (cmd.mul_old) begin
      acc_r <= acc_r + 32'(old_val) * W_OLD;
    end
    if (cmd.update) begin
      frac_r <= (scaled > Q_ONE) ? Q_ONE[16:0] : scaled[16:0];
      bx_r   <= '0;
    end
    if (cmd.height) begin
      h_r <= hprod[22:16];
    end
    if (cmd.emit_load) begin
      bx_r <= bx_r + 1'b1;
    end
  end

  // column position
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;

  assign col          = COL_W'(idx_r) * COL_W'(BAR_WIDTH) + COL_W'(bx_r);
  assign col_next     = col + 1'b1;
  assign sts.col_ok   = (bx_r < BX_W'(BAR_WIDTH)) && (col < COL_W'(disp_w_r));
  assign sts.col_last = (bx_r + 1'b1 == BX_W'(BAR_WIDTH)) ||
                        !(col_next < COL_W'(disp_w_r));

  // output register
  logic                out_valid_r;
  logic [OUT_TD_W-1:0] out_data_r;
  logic                out_last_r;

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data_r <= {1'b0, bar_color_r[7:0], bar_color_r[15:8], bar_color_r[23:16],
                     h_r, col[COL_OUT_W-1:0]};
      out_last_r <= sts.col_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/core/spectrum_bar_smoother_core.sv
// spectrum bar smoother top level: per-bucket ema store driving bar heights
// a bucket passes through the accept, multiply, update and height states in order, then the emit state loads its
// columns into the output register, waiting while that register is full; a new bucket is taken only once the last
//   one is done, since the read, two multiply-accumulate steps and the height multiply run in sequence
// reset: synchronous active-low rst_n clears the store valid bits (all buckets read as zero),
//   loads the register defaults and empties the output register; no clearing pass
module spectrum_bar_smoother_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // bucket_index [5:0], bucket_energy [21:6], zero pad [23:22]
  input  logic [sbs_pkg::IN_TD_W-1:0]   in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // column [7:0], bar_height [14:8], red [22:15], green [30:23], blue [38:31], pad [39]
  output logic [sbs_pkg::OUT_TD_W-1:0]  out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [sbs_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [sbs_pkg::CLR_W-1:0]     cfg_wdata
);
  import sbs_pkg::*;

  sbs_cmd_t cmd;
  sbs_sts_t sts;

  sbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> sts.out_free)
    else $error("output register overwritten");

  // steps of one item never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.mul_old, cmd.update, cmd.height, cmd.emit_load}))
    else $error("overlapping datapath commands");

  // an in-range transfer closes the input until the item is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.in_ok) |=> !in_tready)
    else $error("input open while an item is in work");

  // the store update is followed by the height step
  a_upd_then_hgt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> cmd.height)
    else $error("height step missing after update");

endmodule

### tb/sbs_bar_checker.sv
// stream monitor, bar slice predictor and result scoreboard for the spectrum bar smoother
module sbs_bar_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sbs_pkg::IN_TD_W-1:0]   in_tdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [sbs_pkg::OUT_TD_W-1:0]  out_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [sbs_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [sbs_pkg::CLR_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            slices_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbs_pkg::*;

  // q0.16 ema weights, rounding offset, full scale and the x20 gain
  localparam logic [63:0] EMA_GAIN_NEW = 64'd19661;
  localparam logic [63:0] EMA_GAIN_OLD = 64'd45875;
  localparam logic [63:0] ROUND_HALF   = 64'd32768;
  localparam logic [31:0] FULL_SCALE   = 32'd65536;
  localparam logic [31:0] BAR_GAIN     = 32'd20;

  // one column of a bar as it leaves the block
  typedef struct packed {
    logic       pad;
    logic [7:0] column;
    logic [6:0] bar_height;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_column;
  } bar_slice_t;

  logic [15:0] ema_store [BUCKETS];
  logic [23:0] color_q;
  logic [7:0]  width_q;
  logic [6:0]  height_q;
  bar_slice_t  bar_slices_due [$];
  bar_slice_t  want;
  bar_slice_t  got;

  initial begin
    fail_count = 0;
    slices_due = 0;
  end

  // update the bucket's ema and queue the columns it lights
  task automatic smooth_bucket(input int idx, input logic [15:0] energy);
    logic [63:0] acc;
    logic [31:0] frac;
    logic [31:0] lit;
    bar_slice_t  sl;
    int          first_col;
    int          n_cols;
    if (idx >= BUCKETS) return;
    acc = (EMA_GAIN_NEW * energy + EMA_GAIN_OLD * ema_store[idx] + ROUND_HALF) >> 16;
    if (acc > 64'hFFFF) acc = 64'hFFFF;
    ema_store[idx] = acc[15:0];
    frac = 32'(acc[15:0]) * BAR_GAIN;
    if (frac > FULL_SCALE) frac = FULL_SCALE;
    lit = (frac * height_q + 32'(ROUND_HALF)) >> 16;
    first_col = idx * BAR_WIDTH;
    n_cols = 0;
    while (n_cols < BAR_WIDTH && first_col + n_cols < int'(width_q)) n_cols++;
    for (int bx = 0; bx < n_cols; bx++) begin
      sl.pad         = 1'b0;
      sl.column      = 8'(first_col + bx);
      sl.bar_height  = lit[6:0];
      sl.red         = color_q[23:16];
      sl.green       = color_q[15:8];
      sl.blue        = color_q[7:0];
      sl.last_column = (bx == n_cols - 1);
      bar_slices_due.push_back(sl);
    end
  endtask

  // sample every channel at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (ema_store[i]) ema_store[i] = '0;
      color_q  = BAR_COLOR_RST;
      width_q  = DISP_W_RST;
      height_q = DISP_H_RST;
      bar_slices_due.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_BAR_COLOR:      color_q  = cfg_wdata;
          REG_DISPLAY_WIDTH:  width_q  = cfg_wdata[7:0];
          REG_DISPLAY_HEIGHT: height_q = cfg_wdata[6:0];
          default: ;
        endcase
      end
      // bucket sample transfer
      if (in_tvalid && in_tready) smooth_bucket(int'(in_tdata[5:0]), in_tdata[21:6]);
      // bar slice transfer
      if (out_tvalid && out_tready) begin
        got.pad         = out_tdata[39];
        got.column      = out_tdata[7:0];
        got.bar_height  = out_tdata[14:8];
        got.red         = out_tdata[22:15];
        got.green       = out_tdata[30:23];
        got.blue        = out_tdata[38:31];
        got.last_column = out_tlast;
        if (bar_slices_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected slice: col %0d h %0d rgb %h%h%h last %0d",
                     got.column, got.bar_height, got.red, got.green, got.blue,
                     got.last_column);
        end else begin
          want = bar_slices_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("slice mismatch: want col %0d h %0d rgb %h%h%h last %0d pad %0d",
                       want.column, want.bar_height, want.red, want.green, want.blue,
                       want.last_column, want.pad);
              $display("                got  col %0d h %0d rgb %h%h%h last %0d pad %0d",
                       got.column, got.bar_height, got.red, got.green, got.blue,
                       got.last_column, got.pad);
            end
          end
        end
      end
    end
    slices_due = bar_slices_due.size();
  end

endmodule

### tb/testbench.sv
// top of the spectrum bar smoother bench: clock, reset, bucket stimulus, output stalls, verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 16;
  localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;

  // output stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [IN_TD_W-1:0]  in_tdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OUT_TD_W-1:0] out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CLR_W-1:0]    cfg_wdata = '0;
  int                  fail_count;
  int                  slices_due;

  int       cycle_count = 0;
  int       burst_left = 4;
  int       hold_request = 0;
  int       hold_left = 0;
  int       rx_span = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       cur_width = 32;

  always #10 clk = ~clk;

  spectrum_bar_smoother_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  sbs_bar_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .slices_due (slices_due)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // output side: long hold-offs on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(16, 80);
      end
      rx_span--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= (rx_tick % 5) != 0;
      endcase
    end
  end

  // one bucket sample transfer, then maybe a gap ending the burst
  task automatic send_bucket(input logic [5:0] idx, input logic [15:0] energy);
    in_tdata  <= {2'b00, energy, idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // stop offering and let every expected slice drain
  task automatic drain;
    in_tvalid <= 1'b0;
    while (slices_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // program all registers back to back; the block is idle here
  task automatic program_display(input logic [23:0] color, input logic [23:0] width_word,
                                 input logic [23:0] height_word, input logic poke_spare);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BAR_COLOR;
    cfg_wdata <= color;
    @(negedge clk);
    cfg_addr  <= REG_DISPLAY_WIDTH;
    cfg_wdata <= width_word;
    @(negedge clk);
    cfg_addr  <= REG_DISPLAY_HEIGHT;
    cfg_wdata <= height_word;
    @(negedge clk);
    if (poke_spare) begin
      cfg_addr  <= REG_SPARE;
      cfg_wdata <= 24'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_width = int'(width_word[7:0]);
  endtask

  // random phase setup with junk in the unused upper data bits
  task automatic random_setup(input logic [23:0] color, input int width, input int height);
    program_display(color, {16'($urandom), 8'(width)}, {17'($urandom), 7'(height)},
                    1'($urandom_range(0, 1)));
  endtask

  // mostly buckets that land on the display, energies biased below saturation
  task automatic send_random;
    int          reach;
    logic [5:0]  idx;
    logic [15:0] energy;
    reach = (cur_width > 0) ? (cur_width - 1) / BAR_WIDTH : 63;
    if (reach > 63) reach = 63;
    if ($urandom_range(0, 9) < 8) idx = 6'($urandom_range(0, reach));
    else idx = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 5))
      0:       energy = 16'h0000;
      1:       energy = 16'hFFFF;
      2, 3:    energy = 16'($urandom_range(0, 4095));
      default: energy = 16'($urandom_range(0, 65535));
    endcase
    send_bucket(idx, energy);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: silence, full scale, saturation climb, display edge, small levels
    send_bucket(6'd0, 16'h0000);
    send_bucket(6'd0, 16'hFFFF);
    send_bucket(6'd1, 16'hFFFF);
    send_bucket(6'd1, 16'hFFFF);
    send_bucket(6'd1, 16'hFFFF);
    send_bucket(6'd15, 16'h0CCC);
    send_bucket(6'd16, 16'h1234);
    send_bucket(6'd63, 16'hFFFF);
    send_bucket(6'd5, 16'h0001);
    send_bucket(6'd6, 16'h0666);
    drain();

    // widest display, tallest height, spare register poked
    program_display(24'h123456, 24'd255, 24'd127, 1'b1);
    send_bucket(6'd63, 16'h8000);
    send_bucket(6'd16, 16'hFFFF);
    send_bucket(6'd0, 16'h0001);
    drain();

    // zero width and zero height: nothing comes out, state still moves
    program_display(24'h000000, 24'd0, 24'd0, 1'b0);
    send_bucket(6'd0, 16'hFFFF);
    send_bucket(6'd10, 16'hFFFF);
    drain();

    // odd width cuts the bar of the edge bucket to one column
    program_display(24'h000000, 24'd33, 24'd64, 1'b0);
    send_bucket(6'd16, 16'hFFFF);
    send_bucket(6'd15, 16'h0800);
    send_bucket(6'd0, 16'h0000);
    drain();

    // random phase: extreme width and height
    random_setup(24'($urandom), 255, 127);
    repeat (30) send_random();
    drain();

    // random phase: single column, zero height, only bucket 0 gives results
    random_setup(24'h000000, 1, 0);
    repeat (30) send_random();
    drain();

    // random phase: long output hold-off while samples keep coming
    random_setup(24'hFFFFFF, $urandom_range(2, 128), 64);
    repeat (10) send_random();
    hold_request = 400;
    repeat (20) send_random();
    drain();

    // random phase: sender pauses until all slices are out
    random_setup(24'($urandom), $urandom_range(1, 255), $urandom_range(1, 127));
    repeat (15) send_random();
    in_tvalid <= 1'b0;
    while (slices_due != 0) @(negedge clk);
    repeat (15) send_random();
    drain();

    // random phase: every bucket on display
    random_setup(24'($urandom), 128, $urandom_range(1, 64));
    repeat (30) send_random();
    drain();

    if (fail_count == 0 && slices_due == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
